>>> rtl/per_source_sequence_extender_defines.svh
// ----------------------------------------------------------------------------
// per_source_sequence_extender_defines
// assertion macros shared by the sequence extender checks
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_SEQUENCE_EXTENDER_DEFINES_SVH
`define PER_SOURCE_SEQUENCE_EXTENDER_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define PSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequence extender check failed");

// next-cycle implication, clocked on clk, quiet during reset
`define PSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence extender check failed");

`endif

>>> rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// types and constants for the per-source sequence extender
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int NUM_W  = 8;
    localparam int ADDR_W = 16;
    localparam int EXT_W  = 16;

    localparam logic [NUM_W-1:0]  THRESHOLD_RESET = 8'd250;
    localparam logic [ADDR_W-1:0] FREE_ADDR       = 16'h0000;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_UPDATED = 2'd0,
        OUT_CLAIMED = 2'd1,
        OUT_FULL    = 2'd2
    } outcome_t;

    // search token walking down the cell row
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        logic              done;
        logic [EXT_W-1:0]  ext;
        outcome_t          outcome;
    } pse_tok_t;

endpackage

>>> rtl/per_source_sequence_extender.sv
// A beat enters a row of ENTRIES cells, one table entry per cell, and its search token
// moves one cell per clock; the first cell that matches the source address or is free
// settles the result, and later cells pass it on. An accepted beat is registered as the head
// token, passes through each cell's register in turn, and the result from the last cell goes
// to the output register, or to the pending slot while the output is stalled.
// One item is in the row at a time; the next beat is taken once the previous result has
// left the row and the pending slot, even while that result still waits at the output.
// ----------------------------------------------------------------------------
// per_source_sequence_extender
// extends 8-bit sequence numbers with a per-source wrap count
// ----------------------------------------------------------------------------
`include "per_source_sequence_extender_defines.svh"

module per_source_sequence_extender
    import pse_pkg::*;
#(
    parameter int ENTRIES = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [NUM_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [NUM_W-1:0]  seq_number,
    input  logic [ADDR_W-1:0] src_addr,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [EXT_W-1:0]  extended_number,
    output logic [1:0]        outcome
);

    logic [NUM_W-1:0] threshold_reg;
    logic             busy_reg,       busy_next;
    logic             head_valid_reg;
    pse_tok_t         head_tok_reg;
    logic             pend_valid_reg, pend_valid_next;
    pse_tok_t         pend_tok_reg,   pend_tok_next;
    logic             out_valid_reg,  out_valid_next;
    pse_tok_t         out_tok_reg,    out_tok_next;

    logic [ENTRIES-1:0] chain_valid;
    pse_tok_t           chain_tok [ENTRIES];

    logic     accept;
    logic     tail_valid;
    pse_tok_t tail_tok;
    logic     out_free;

    assign accept     = in_valid & ~in_stall;
    assign in_stall   = busy_reg | pend_valid_reg;
    assign tail_valid = chain_valid[ENTRIES-1];
    assign tail_tok   = chain_tok[ENTRIES-1];
    assign out_free   = ~out_valid_reg | ~out_stall;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // head token, loaded from the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_tok_reg.num     <= seq_number;
            head_tok_reg.addr    <= src_addr;
            head_tok_reg.done    <= 1'b0;
            head_tok_reg.ext     <= '0;
            head_tok_reg.outcome <= OUT_FULL;
        end
    end

    // row of table cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            pse_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .threshold (threshold_reg),
                .in_valid  (head_valid_reg),
                .in_tok    (head_tok_reg),
                .out_valid (chain_valid[i]),
                .out_tok   (chain_tok[i])
            );
        end
        else
        begin : g_rest
            pse_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .threshold (threshold_reg),
                .in_valid  (chain_valid[i-1]),
                .in_tok    (chain_tok[i-1]),
                .out_valid (chain_valid[i]),
                .out_tok   (chain_tok[i])
            );
        end
    end

    // busy tracking and result hand-off to output or pending slot
    always_comb
    begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_tok_next    = out_tok_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail_valid)
        begin
            busy_next = 1'b0;
        end

        if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_tok_next    = pend_tok_reg;
            pend_valid_next = 1'b0;
        end
        else if (tail_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_tok_next   = tail_tok;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_tok_next   = tail_tok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tok_reg <= pend_tok_next;
        out_tok_reg  <= out_tok_next;
    end

    // output beat
    assign out_valid       = out_valid_reg;
    assign extended_number = out_tok_reg.ext;
    assign outcome         = out_tok_reg.outcome;

    // checks
    `PSE_ASSERT_NOW(a_single_token, 1'b1, $onehot0({head_valid_reg, chain_valid}))
    `PSE_ASSERT_NOW(a_token_means_busy, (head_valid_reg || (|chain_valid)), busy_reg)
    `PSE_ASSERT_NOW(a_pend_behind_out, pend_valid_reg, out_valid_reg)
    `PSE_ASSERT_NEXT(a_accept_starts_walk, accept, (busy_reg && head_valid_reg))

endmodule

>>> rtl/pse_cell.sv
// ----------------------------------------------------------------------------
// pse_cell
// one table entry; checks the passing token and hands it to the next cell
// ----------------------------------------------------------------------------
module pse_cell
    import pse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NUM_W-1:0] threshold,
    input  logic             in_valid,
    input  pse_tok_t         in_tok,
    output logic             out_valid,
    output pse_tok_t         out_tok
);

    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic [NUM_W-1:0]  last_reg,  last_next;
    logic [NUM_W-1:0]  count_reg, count_next;
    logic              valid_reg;
    pse_tok_t          tok_reg,   tok_next;

    logic              live;
    logic              hit;
    logic              claim;
    logic [NUM_W-1:0]  drop;
    logic              wrap;
    logic [NUM_W-1:0]  count_upd;

    // match or free-slot decision for this entry
    always_comb
    begin
        live      = in_valid & ~in_tok.done;
        hit       = live & (in_tok.addr == addr_reg);
        claim     = live & ~hit & (addr_reg == FREE_ADDR);
        drop      = last_reg - in_tok.num;
        wrap      = (last_reg > in_tok.num) & (drop > threshold);
        count_upd = count_reg + NUM_W'(wrap);

        addr_next  = addr_reg;
        last_next  = last_reg;
        count_next = count_reg;
        tok_next   = in_tok;

        if (hit)
        begin
            last_next        = in_tok.num;
            count_next       = count_upd;
            tok_next.done    = 1'b1;
            tok_next.ext     = {count_upd, in_tok.num};
            tok_next.outcome = OUT_UPDATED;
        end
        else if (claim)
        begin
            addr_next        = in_tok.addr;
            last_next        = in_tok.num;
            count_next       = '0;
            tok_next.done    = 1'b1;
            tok_next.ext     = {{(EXT_W-NUM_W){1'b0}}, in_tok.num};
            tok_next.outcome = OUT_CLAIMED;
        end
    end

    // entry state, cleared to free at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= FREE_ADDR;
            last_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            valid_reg <= in_valid;
        end
    end

    // token payload toward the next cell
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

>>> test/tb_per_source_sequence_extender.sv
// ----------------------------------------------------------------------------
// tb_per_source_sequence_extender
// self-checking bench for the per-source sequence number extender
//
// A short table of directed beats covers the number and address extremes,
// the wrap decision at each threshold extreme, the all-zero address and the claiming of
// a slot that the all-zero address touched. Random traffic follows. It runs
// tracked per-source sequences that wrap past 255, one source hammered with
// descending numbers so its wrap count rolls over, and fresh sources that
// fill the table until it reports full. Every result beat is checked against
// the typed result of its directed row, else a bit-accurate predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_per_source_sequence_extender;
    import pse_pkg::*;

    localparam int TABLE_DEPTH    = 128;
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DIRECTED_COUNT = 24;

    typedef struct packed {
        logic [EXT_W-1:0] ext;
        outcome_t         oc;
    } extension_t;

    typedef enum logic {ROW_BEAT, ROW_THRESHOLD} row_kind_t;

    // a threshold row carries the new register value in num
    typedef struct packed {
        row_kind_t         kind;
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        logic [EXT_W-1:0]  ext;
        outcome_t          oc;
    } directed_row_t;

    typedef enum {MIX_TRACKED, MIX_HAMMER, MIX_FILL} traffic_mix_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [NUM_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [NUM_W-1:0]  seq_number = '0;
    logic [ADDR_W-1:0] src_addr = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [EXT_W-1:0]  extended_number;
    logic [1:0]        outcome;

    // bench copy of the block state
    logic [ADDR_W-1:0] src_table [TABLE_DEPTH];
    logic [NUM_W-1:0]  last_table [TABLE_DEPTH];
    logic [7:0]        wraps_table [TABLE_DEPTH];
    logic [NUM_W-1:0]  wrap_threshold = THRESHOLD_RESET;

    extension_t        awaited_extensions [$];
    int                mismatch_count = 0;
    int                result_count = 0;
    int                quiet_cycles = 0;
    int                idle_pct = 23;

    // sources with tracked sequence numbers
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    logic [NUM_W-1:0]  pool_next [POOL_SIZE];

    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{ROW_BEAT,      8'h00, 16'h0001, 1'b1, 16'h0000, OUT_CLAIMED},
        '{ROW_BEAT,      8'hff, 16'hffff, 1'b1, 16'h00ff, OUT_CLAIMED},
        '{ROW_BEAT,      8'h05, 16'h0001, 1'b1, 16'h0005, OUT_UPDATED},
        '{ROW_BEAT,      8'hff, 16'h0001, 1'b1, 16'h00ff, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'h0001, 1'b1, 16'h0100, OUT_UPDATED},
        '{ROW_BEAT,      8'h04, 16'hffff, 1'b1, 16'h0104, OUT_UPDATED},
        '{ROW_BEAT,      8'h05, 16'hffff, 1'b1, 16'h0105, OUT_UPDATED},
        '{ROW_BEAT,      8'h10, 16'h0000, 1'b1, 16'h0010, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'h0000, 1'b1, 16'h0000, OUT_UPDATED},
        '{ROW_BEAT,      8'h77, 16'h1234, 1'b1, 16'h0077, OUT_CLAIMED},
        '{ROW_BEAT,      8'h55, 16'haaaa, 1'b1, 16'h0055, OUT_CLAIMED},
        '{ROW_BEAT,      8'haa, 16'h5555, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_BEAT,      8'h3c, 16'h0000, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_THRESHOLD, 8'h00, 16'h0000, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_BEAT,      8'h01, 16'h0001, 1'b1, 16'h0101, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'h0001, 1'b1, 16'h0200, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'h0001, 1'b1, 16'h0200, OUT_UPDATED},
        '{ROW_BEAT,      8'h80, 16'haaaa, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_THRESHOLD, 8'hff, 16'h0000, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'hffff, 1'b1, 16'h0100, OUT_UPDATED},
        '{ROW_BEAT,      8'hff, 16'hffff, 1'b1, 16'h01ff, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'hffff, 1'b1, 16'h0100, OUT_UPDATED},
        '{ROW_THRESHOLD, 8'hfa, 16'h0000, 1'b0, 16'h0000, OUT_UPDATED},
        '{ROW_BEAT,      8'h00, 16'h5555, 1'b0, 16'h0000, OUT_UPDATED}
    };

    per_source_sequence_extender #(
        .ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .seq_number(seq_number),
        .src_addr(src_addr),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .extended_number(extended_number),
        .outcome(outcome)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scan for the first matching or free slot and update the bench state
    function automatic extension_t extend_sequence(input logic [NUM_W-1:0] num,
                                                   input logic [ADDR_W-1:0] addr);
        extension_t res;
        int         drop;
        res.ext = '0;
        res.oc  = OUT_FULL;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (src_table[i] == addr)
            begin
                drop = int'(last_table[i]) - int'(num);
                if (drop > int'(wrap_threshold))
                    wraps_table[i] = wraps_table[i] + 8'd1;
                last_table[i] = num;
                res.ext = {wraps_table[i], num};
                res.oc  = OUT_UPDATED;
                return res;
            end
            if (src_table[i] == FREE_ADDR)
            begin
                src_table[i]   = addr;
                last_table[i]  = num;
                wraps_table[i] = 8'd0;
                res.ext = {8'd0, num};
                res.oc  = OUT_CLAIMED;
                return res;
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // present one input beat, with a random gap first, and wait for acceptance
    task automatic send_beat(input logic [NUM_W-1:0] num, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = ($urandom_range(7) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        seq_number <= num;
        src_addr   <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // register write only once every awaited result has come back
    task automatic write_threshold(input logic [NUM_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_extensions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write      <= 1'b0;
        wrap_threshold = value;
    endtask

    task automatic run_traffic(input int count, input traffic_mix_t mix);
        int                k;
        int                roll;
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            k    = $urandom_range(POOL_SIZE - 1);
            addr = pool_addr[k];
            num  = pool_next[k];
            if (mix == MIX_HAMMER)
            begin
                // descending numbers: nearly every beat counts a wrap at threshold 0
                addr = pool_addr[0];
                num  = pool_next[0] - NUM_W'($urandom_range(1, 3));
                pool_next[0] = num;
            end
            else if (mix == MIX_FILL && roll < 30)
            begin
                addr = ADDR_W'($urandom_range(1, 65535));
                num  = NUM_W'($urandom);
            end
            else if (roll < 5)
            begin
                addr = FREE_ADDR;
                num  = NUM_W'($urandom);
            end
            else if (roll < 85)
            begin
                pool_next[k] = num + NUM_W'($urandom_range(1, 3));
            end
            else
            begin
                // noise: random number on a tracked or unknown source
                if (roll < 92)
                    addr = ADDR_W'($urandom);
                num = NUM_W'($urandom);
            end
            send_beat(num, addr);
            awaited_extensions.push_back(extend_sequence(num, addr));
        end
    endtask

    // result side: random stall, compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        extension_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (awaited_extensions.size() == 0)
                note_failure($sformatf("result %0d unexpected: extended_number %h outcome %0d",
                                       result_count, extended_number, outcome));
            else
            begin
                want = awaited_extensions.pop_front();
                if (extended_number !== want.ext || outcome !== want.oc)
                    note_failure($sformatf(
                        "result %0d: extended_number exp %h got %h, outcome exp %0d got %0d",
                        result_count, want.ext, extended_number, want.oc, outcome));
            end
        end
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("per_source_sequence_extender test failed");
            $finish;
        end
    end

    initial
    begin
        extension_t res;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            src_table[i]   = FREE_ADDR;
            last_table[i]  = '0;
            wraps_table[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_addr[i] = ADDR_W'($urandom_range(1, 65535));
            pool_next[i] = NUM_W'($urandom);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            if (directed_rows[r].kind == ROW_THRESHOLD)
                write_threshold(directed_rows[r].num);
            else
            begin
                send_beat(directed_rows[r].num, directed_rows[r].addr);
                res = extend_sequence(directed_rows[r].num, directed_rows[r].addr);
                if (directed_rows[r].typed)
                begin
                    res.ext = directed_rows[r].ext;
                    res.oc  = directed_rows[r].oc;
                end
                awaited_extensions.push_back(res);
            end
        end

        // random traffic over several threshold settings
        run_traffic(550, MIX_TRACKED);
        write_threshold(8'd0);
        idle_pct = 0;
        run_traffic(300, MIX_HAMMER);
        idle_pct = 23;
        write_threshold(NUM_W'($urandom_range(1, 254)));
        run_traffic(450, MIX_FILL);
        write_threshold(8'hff);
        run_traffic(150, MIX_TRACKED);
        write_threshold(NUM_W'($urandom_range(1, 254)));
        run_traffic(300, MIX_FILL);
        in_valid <= 1'b0;

        // drain and let the row walk out
        while (awaited_extensions.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("per_source_sequence_extender test passed");
        else
            $display("per_source_sequence_extender test failed");
        $finish;
    end

endmodule
